// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");
// Antecedent in one cycle implies the consequent in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Antecedent in one cycle implies the consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, cond)
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- hdl/oal_pkg.sv -----
// ----------------------------------------------------------------------------
// oal_pkg
// Types and codes shared by the ordered array list modules.
// ----------------------------------------------------------------------------
`default_nettype none

package oal_pkg;

	localparam int CAPACITY_DEF = 128;

	// Request kinds.
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_DELETE = 2'd1;
	localparam logic [1:0] REQ_FIND   = 2'd2;

	// Result status codes.
	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_FULL      = 2'd1;
	localparam logic [1:0] STS_ILLEGAL   = 2'd2;
	localparam logic [1:0] STS_NOT_FOUND = 2'd3;

	localparam int SLOT_W  = 8;
	localparam int FOUND_W = 7;
	localparam int COUNT_W = 8;
	localparam int VALUE_W = 32;

	typedef struct packed {
		logic [1:0]                req_type;
		logic [SLOT_W-1:0]         slot;
		logic signed [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [FOUND_W-1:0] found_slot;
		logic [COUNT_W-1:0] count;
	} res_t;

endpackage

`default_nettype wire

// ----- hdl/oal_ram.sv -----
// ----------------------------------------------------------------------------
// oal_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module oal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- hdl/oal_ctrl.sv -----
// ----------------------------------------------------------------------------
// oal_ctrl
// Sequencer that walks the store one entry per cycle for shifts and search.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module oal_ctrl #(
	parameter int CAPACITY = oal_pkg::CAPACITY_DEF,
	parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire oal_pkg::req_t                 req,
	output logic                               busy,
	output logic                               done,
	output oal_pkg::res_t                      res,
	output logic                               mem_we,
	output logic [AW-1:0]                      mem_waddr,
	output logic [oal_pkg::VALUE_W-1:0]        mem_wdata,
	output logic [AW-1:0]                      mem_raddr,
	input  wire logic [oal_pkg::VALUE_W-1:0]   mem_rdata
);

	import oal_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int WW = ((CW > SLOT_W) ? CW : SLOT_W) + 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_UP    = 3'd1;
	localparam logic [2:0] ST_PUT   = 3'd2;
	localparam logic [2:0] ST_DN    = 3'd3;
	localparam logic [2:0] ST_FLUSH = 3'd4;
	localparam logic [2:0] ST_SCAN  = 3'd5;

	logic [2:0]         state_q;
	logic [CW-1:0]      cnt_q;
	logic               done_q;
	logic               pend_q;
	logic               chk_q;
	res_t               res_q;
	logic [AW-1:0]      rd_q;
	logic [AW-1:0]      pos_q;
	logic [AW-1:0]      wa_q;
	logic [AW-1:0]      ci_q;
	logic [VALUE_W-1:0] val_q;

	logic [WW-1:0] slot_w;
	logic [WW-1:0] cnt_w;
	logic [AW-1:0] last_a;
	logic          match;
	logic          full_ins;

	assign slot_w = WW'(req.slot);
	assign cnt_w  = WW'(cnt_q);
	assign last_a = AW'(cnt_q - CW'(1));
	assign match  = (mem_rdata == val_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			pend_q  <= 1'b0;
			chk_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			pend_q <= (state_q == ST_UP) || (state_q == ST_DN);
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						val_q            <= req.value;
						pos_q            <= AW'(req.slot);
						chk_q            <= 1'b0;
						res_q.found_slot <= '0;
						res_q.count      <= COUNT_W'(cnt_q);
						case (req.req_type)
							REQ_INSERT: begin
								if (cnt_q == CW'(CAPACITY)) begin
									res_q.status <= STS_FULL;
									done_q       <= 1'b1;
								end else if (slot_w > cnt_w) begin
									res_q.status <= STS_ILLEGAL;
									done_q       <= 1'b1;
								end else if (slot_w == cnt_w) begin
									state_q <= ST_PUT;
								end else begin
									rd_q    <= last_a;
									state_q <= ST_UP;
								end
							end
							REQ_DELETE: begin
								if (slot_w >= cnt_w) begin
									res_q.status <= STS_ILLEGAL;
									done_q       <= 1'b1;
								end else if (slot_w + WW'(1) == cnt_w) begin
									// Last entry removed: nothing to move.
									cnt_q        <= cnt_q - CW'(1);
									res_q.status <= STS_OK;
									res_q.count  <= COUNT_W'(cnt_q - CW'(1));
									done_q       <= 1'b1;
								end else begin
									rd_q    <= AW'(req.slot) + AW'(1);
									state_q <= ST_DN;
								end
							end
							REQ_FIND: begin
								if (cnt_q == '0) begin
									res_q.status <= STS_NOT_FOUND;
									done_q       <= 1'b1;
								end else begin
									rd_q    <= '0;
									state_q <= ST_SCAN;
								end
							end
							default: begin
								res_q.status <= STS_ILLEGAL;
								done_q       <= 1'b1;
							end
						endcase
					end
				end
				ST_UP: begin
					wa_q <= rd_q + AW'(1);
					if (rd_q == pos_q) begin
						state_q <= ST_PUT;
					end else begin
						rd_q <= rd_q - AW'(1);
					end
				end
				ST_PUT: begin
					// Waits for the last moved entry before writing the new one.
					if (!pend_q) begin
						cnt_q        <= cnt_q + CW'(1);
						res_q.status <= STS_OK;
						res_q.count  <= COUNT_W'(cnt_q + CW'(1));
						done_q       <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				ST_DN: begin
					wa_q <= rd_q - AW'(1);
					if (rd_q == last_a) begin
						state_q <= ST_FLUSH;
					end else begin
						rd_q <= rd_q + AW'(1);
					end
				end
				ST_FLUSH: begin
					cnt_q        <= cnt_q - CW'(1);
					res_q.status <= STS_OK;
					res_q.count  <= COUNT_W'(cnt_q - CW'(1));
					done_q       <= 1'b1;
					state_q      <= ST_IDLE;
				end
				ST_SCAN: begin
					chk_q <= 1'b1;
					ci_q  <= rd_q;
					rd_q  <= rd_q + AW'(1);
					if (chk_q && match) begin
						res_q.status     <= STS_OK;
						res_q.found_slot <= FOUND_W'(ci_q);
						done_q           <= 1'b1;
						state_q          <= ST_IDLE;
					end else if (chk_q && (ci_q == last_a)) begin
						res_q.status <= STS_NOT_FOUND;
						done_q       <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A pending move has priority; the new value goes in once moves are done.
	assign mem_we    = pend_q || ((state_q == ST_PUT) && !pend_q);
	assign mem_waddr = pend_q ? wa_q : pos_q;
	assign mem_wdata = pend_q ? mem_rdata : val_q;
	assign mem_raddr = rd_q;

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign res  = res_q;

	// Insert transaction taken while the store is full.
	assign full_ins = start && !busy && (req.req_type == REQ_INSERT) &&
		(cnt_q == CW'(CAPACITY));

	`ASSERT_IMPL(a_done_idle, done_q, state_q == ST_IDLE)
	`ASSERT_ALWAYS(a_cnt_range, cnt_q <= CW'(CAPACITY))
	`ASSERT_IMPL(a_flush_pend, state_q == ST_FLUSH, pend_q)
	`ASSERT_IMPL(a_cnt_at_done, !$stable(cnt_q), done_q)
	`ASSERT_NEXT(a_full_ins, full_ins, done_q && (res_q.status == STS_FULL))

endmodule

`default_nettype wire

// ----- hdl/ordered_array_list.sv -----
// Ordered array list: insert, delete and find over a list kept in one RAM.
// Rejected requests finish without a walk. An insert at position p below n
// entries moves the entries from p upwards, a delete those above it, and a
// find reads entries until a match or the last entry; each walk uses the
// single RAM port pair, moving or reading one entry per cycle. One request
// in flight; busy covers it. No result stall. Reset empties the list at once.
// ----------------------------------------------------------------------------
// ordered_array_list
// Sequential list of signed 32-bit values with insert, delete and find.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_array_list #(
	parameter int CAPACITY = oal_pkg::CAPACITY_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire oal_pkg::req_t req,
	output logic               done,
	output oal_pkg::res_t      res
);

	import oal_pkg::*;

	// Address width of the entry store.
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	// Store port signals between the sequencer and the RAM.
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [VALUE_W-1:0] mem_wdata;
	logic [AW-1:0]      mem_raddr;
	logic [VALUE_W-1:0] mem_rdata;

	// The sequencer takes a transaction when start is seen with busy low.
	// Inserts walk from the top of the list down to the insert position,
	// moving each entry up by one: the read of one entry overlaps the write
	// of the entry read in the cycle before. Deletes walk upwards from the
	// entry after the deleted one in the same way. A find reads entries in
	// order and compares each returned word with the search value in the
	// single comparator, stopping at the first match or after the last entry.
	oal_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.done      (done),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// Entry store. Its contents are not cleared by reset: only positions
	// below the count are ever read for a result, and each has been written.
	oal_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

`default_nettype wire
